// File: rtl/core/nonpreemptive_priority_scheduler_macros.svh
// Assertion macros for the priority scheduler checker.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/nps_pkg.sv
// Shared types and constants for the priority scheduler.
package nps_pkg;

	localparam int ARR_W        = 16;
	localparam int BUR_W        = 16;
	localparam int PRI_W        = 8;
	localparam int TIME_W       = 21;
	localparam int SUM_W        = 25;
	localparam int NUM_W        = 5;
	localparam int ENT_W        = ARR_W + BUR_W + PRI_W;
	localparam int MAX_JOBS_DEF = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_COMP,
		ST_TAT,
		ST_EMIT
	} nps_state_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan;
		logic pick;
		logic comp;
		logic tat;
		logic emit;
		logic clear;
	} nps_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic last_pick;
		logic out_valid;
	} nps_stat_t;

endpackage

// File: rtl/core/nonpreemptive_priority_scheduler.sv
// Top level of the non-preemptive priority scheduler.
//
//   channel  | handshake             | beat
//   ---------+-----------------------+----------------------------------------------
//   job in   | start, busy           | arrival_time, burst_time, priority_level, last_job
//   result   | result_valid (strobe) | job_number .. total_waiting, last_result
//
// A job beat without last_job is stored unless the job memory is full; busy stays low.
// A beat with last_job starts the run: each result comes from one pass over the job
// memory (one read port) plus four arithmetic steps.
// busy drops the cycle after the last result; the run state is cleared as that result is registered.
// Reset is asynchronous; the memory holds no reset. Results cannot be stalled.
module nonpreemptive_priority_scheduler
	import nps_pkg::*;
#(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ARR_W-1:0]  arrival_time,
	input  logic [BUR_W-1:0]  burst_time,
	input  logic [PRI_W-1:0]  priority_level,
	input  logic              last_job,
	output logic              result_valid,
	output logic [NUM_W-1:0]  job_number,
	output logic [ARR_W-1:0]  job_arrival,
	output logic [BUR_W-1:0]  job_burst,
	output logic [TIME_W-1:0] completion_time,
	output logic [TIME_W-1:0] turnaround_time,
	output logic [TIME_W-1:0] waiting_time,
	output logic [SUM_W-1:0]  total_turnaround,
	output logic [SUM_W-1:0]  total_waiting,
	output logic              last_result
);

	nps_cmd_t  cmd;
	nps_stat_t stat;

	nps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_job (last_job),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	nps_dp #(
		.MAX_JOBS (MAX_JOBS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.arrival_time     (arrival_time),
		.burst_time       (burst_time),
		.priority_level   (priority_level),
		.result_valid     (result_valid),
		.job_number       (job_number),
		.job_arrival      (job_arrival),
		.job_burst        (job_burst),
		.completion_time  (completion_time),
		.turnaround_time  (turnaround_time),
		.waiting_time     (waiting_time),
		.total_turnaround (total_turnaround),
		.total_waiting    (total_waiting),
		.last_result      (last_result)
	);

endmodule

// File: rtl/core/nps_ctrl.sv
// Controller state machine: load, scan, pick, compute, turnaround, emit sequencing.
module nps_ctrl
	import nps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      last_job,
	input  nps_stat_t stat,
	output nps_cmd_t  cmd,
	output logic      busy
);

	nps_state_t state_q;
	nps_state_t state_nxt;
	logic       accept;

	assign accept = (state_q == ST_IDLE) && start && !stat.out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && last_job) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_end) state_nxt = ST_PICK;
			end
			ST_PICK: state_nxt = ST_COMP;
			ST_COMP: state_nxt = ST_TAT;
			ST_TAT:  state_nxt = ST_EMIT;
			ST_EMIT: begin
				state_nxt = stat.last_pick ? ST_IDLE : ST_SCAN;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE) || stat.out_valid;
		case (state_q)
			ST_IDLE: begin
				cmd.load     = accept;
				cmd.scan_clr = accept && last_job;
			end
			ST_SCAN: cmd.scan = 1'b1;
			ST_PICK: cmd.pick = 1'b1;
			ST_COMP: cmd.comp = 1'b1;
			ST_TAT:  cmd.tat  = 1'b1;
			ST_EMIT: begin
				cmd.emit     = 1'b1;
				cmd.scan_clr = !stat.last_pick;
				cmd.clear    = stat.last_pick;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/core/nps_dp.sv
// Datapath: job memory, selection scan, time arithmetic and result registers.
module nps_dp
	import nps_pkg::*;
#(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nps_cmd_t          cmd,
	output nps_stat_t         stat,
	input  logic [ARR_W-1:0]  arrival_time,
	input  logic [BUR_W-1:0]  burst_time,
	input  logic [PRI_W-1:0]  priority_level,
	output logic              result_valid,
	output logic [NUM_W-1:0]  job_number,
	output logic [ARR_W-1:0]  job_arrival,
	output logic [BUR_W-1:0]  job_burst,
	output logic [TIME_W-1:0] completion_time,
	output logic [TIME_W-1:0] turnaround_time,
	output logic [TIME_W-1:0] waiting_time,
	output logic [SUM_W-1:0]  total_turnaround,
	output logic [SUM_W-1:0]  total_waiting,
	output logic              last_result
);

	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	// job memory
	logic [ENT_W-1:0] mem [MAX_JOBS];
	logic [ENT_W-1:0] rd_q;
	logic             we;
	logic             re;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [CNT_W-1:0]    k_q;
	logic [MAX_JOBS-1:0] done_q;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [ARR_W-1:0] rd_arr;
	logic [BUR_W-1:0] rd_bur;
	logic [PRI_W-1:0] rd_pri;

	logic             best_found_q;
	logic [ARR_W-1:0] best_arr_q;
	logic [BUR_W-1:0] best_bur_q;
	logic [PRI_W-1:0] best_pri_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             min_found_q;
	logic [ARR_W-1:0] min_arr_q;
	logic [BUR_W-1:0] min_bur_q;
	logic [PRI_W-1:0] min_pri_q;
	logic [IDX_W-1:0] min_idx_q;

	logic [IDX_W-1:0]  sel_idx_q;
	logic [ARR_W-1:0]  sel_arr_q;
	logic [BUR_W-1:0]  sel_bur_q;
	logic [TIME_W-1:0] clock_q;
	logic [TIME_W-1:0] comp_q;
	logic [TIME_W-1:0] tat_q;
	logic [SUM_W-1:0]  sum_tat_q;
	logic [SUM_W-1:0]  sum_wt_q;

	logic              cand_open;
	logic              arrived;
	logic              upd_best;
	logic              upd_min;
	logic [TIME_W:0]   comp_sum;
	logic [TIME_W-1:0] comp_sat;
	logic [TIME_W-1:0] wt_val;
	logic [SUM_W:0]    tat_acc;
	logic [SUM_W:0]    wt_acc;
	logic [SUM_W-1:0]  tat_sat;
	logic [SUM_W-1:0]  wt_sat;
	logic [IDX_W:0]    num_full;

	logic              out_valid_q;
	logic [NUM_W-1:0]  o_num_q;
	logic [ARR_W-1:0]  o_arr_q;
	logic [BUR_W-1:0]  o_bur_q;
	logic [TIME_W-1:0] o_comp_q;
	logic [TIME_W-1:0] o_tat_q;
	logic [TIME_W-1:0] o_wt_q;
	logic [SUM_W-1:0]  o_sum_tat_q;
	logic [SUM_W-1:0]  o_sum_wt_q;
	logic              o_last_q;

	assign we = cmd.load && (count_q < CNT_W'(MAX_JOBS));
	assign re = cmd.scan && (rd_idx_q < count_q);

	always_ff @(posedge clk) begin
		if (we) mem[count_q[IDX_W-1:0]] <= {arrival_time, burst_time, priority_level};
		if (re) rd_q <= mem[rd_idx_q[IDX_W-1:0]];
	end

	assign {rd_arr, rd_bur, rd_pri} = rd_q;

	// scan compare
	assign cand_open = vld_s1 && !done_q[idx_s1];
	assign arrived   = TIME_W'(rd_arr) <= clock_q;
	assign upd_best  = cand_open && arrived && (!best_found_q || (rd_pri < best_pri_q) ||
		((rd_pri == best_pri_q) && (rd_arr < best_arr_q)));
	assign upd_min   = cand_open && (!min_found_q || (rd_arr < min_arr_q) ||
		((rd_arr == min_arr_q) && (rd_pri < min_pri_q)));

	assign stat.scan_end  = (rd_idx_q == count_q) && !vld_s1;
	assign stat.last_pick = (k_q == CNT_W'(count_q - 1'b1));
	assign stat.out_valid = out_valid_q;

	// arithmetic
	assign comp_sum = {1'b0, clock_q} + (TIME_W + 1)'(sel_bur_q);
	assign comp_sat = comp_sum[TIME_W] ? {TIME_W{1'b1}} : comp_sum[TIME_W-1:0];
	assign wt_val   = (tat_q >= TIME_W'(sel_bur_q)) ? (tat_q - TIME_W'(sel_bur_q)) : '0;
	assign tat_acc  = {1'b0, sum_tat_q} + (SUM_W + 1)'(tat_q);
	assign wt_acc   = {1'b0, sum_wt_q} + (SUM_W + 1)'(wt_val);
	assign tat_sat  = tat_acc[SUM_W] ? {SUM_W{1'b1}} : tat_acc[SUM_W-1:0];
	assign wt_sat   = wt_acc[SUM_W] ? {SUM_W{1'b1}} : wt_acc[SUM_W-1:0];
	assign num_full = {1'b0, sel_idx_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			rd_idx_q     <= '0;
			k_q          <= '0;
			done_q       <= '0;
			vld_s1       <= 1'b0;
			best_found_q <= 1'b0;
			min_found_q  <= 1'b0;
			clock_q      <= '0;
			sum_tat_q    <= '0;
			sum_wt_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= cmd.emit;
			if (we) count_q <= count_q + 1'b1;
			if (cmd.scan_clr) begin
				rd_idx_q     <= '0;
				vld_s1       <= 1'b0;
				best_found_q <= 1'b0;
				min_found_q  <= 1'b0;
			end else if (cmd.scan) begin
				vld_s1 <= re;
				if (re) rd_idx_q <= rd_idx_q + 1'b1;
				if (upd_best) best_found_q <= 1'b1;
				if (upd_min) min_found_q <= 1'b1;
			end
			if (cmd.pick && !best_found_q) clock_q <= TIME_W'(min_arr_q);
			if (cmd.tat) clock_q <= comp_q;
			if (cmd.emit && !cmd.clear) begin
				done_q[sel_idx_q] <= 1'b1;
				k_q               <= k_q + 1'b1;
				sum_tat_q         <= tat_sat;
				sum_wt_q          <= wt_sat;
			end
			if (cmd.clear) begin
				count_q   <= '0;
				k_q       <= '0;
				done_q    <= '0;
				clock_q   <= '0;
				sum_tat_q <= '0;
				sum_wt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && re) idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (cmd.scan && upd_best) begin
			best_arr_q <= rd_arr;
			best_bur_q <= rd_bur;
			best_pri_q <= rd_pri;
			best_idx_q <= idx_s1;
		end
		if (cmd.scan && upd_min) begin
			min_arr_q <= rd_arr;
			min_bur_q <= rd_bur;
			min_pri_q <= rd_pri;
			min_idx_q <= idx_s1;
		end
		if (cmd.pick) begin
			sel_idx_q <= best_found_q ? best_idx_q : min_idx_q;
			sel_arr_q <= best_found_q ? best_arr_q : min_arr_q;
			sel_bur_q <= best_found_q ? best_bur_q : min_bur_q;
		end
		if (cmd.comp) comp_q <= comp_sat;
		if (cmd.tat) tat_q <= comp_q - TIME_W'(sel_arr_q);
		if (cmd.emit) begin
			o_num_q     <= NUM_W'(num_full);
			o_arr_q     <= sel_arr_q;
			o_bur_q     <= sel_bur_q;
			o_comp_q    <= clock_q;
			o_tat_q     <= tat_q;
			o_wt_q      <= wt_val;
			o_sum_tat_q <= tat_sat;
			o_sum_wt_q  <= wt_sat;
			o_last_q    <= stat.last_pick;
		end
	end

	assign result_valid     = out_valid_q;
	assign job_number       = o_num_q;
	assign job_arrival      = o_arr_q;
	assign job_burst        = o_bur_q;
	assign completion_time  = o_comp_q;
	assign turnaround_time  = o_tat_q;
	assign waiting_time     = o_wt_q;
	assign total_turnaround = o_sum_tat_q;
	assign total_waiting    = o_sum_wt_q;
	assign last_result      = o_last_q;

endmodule

// File: rtl/core/nps_checker.sv
// Port-level checker for the priority scheduler, bound to the top level.
`include "nonpreemptive_priority_scheduler_macros.svh"

module nps_assert_checker
	import nps_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              last_job,
	input logic              result_valid,
	input logic [ARR_W-1:0]  job_arrival,
	input logic [TIME_W-1:0] completion_time,
	input logic [TIME_W-1:0] turnaround_time,
	input logic              last_result
);

	logic [TIME_W-1:0] tat_exp;

	assign tat_exp = completion_time - TIME_W'(job_arrival);

	`NPS_ASSERT_NOW(a_result_busy, result_valid, busy, "result beat while not busy")
	`NPS_ASSERT_NEXT(a_last_idle, result_valid && last_result, !busy, "busy after last result")
	`NPS_ASSERT_NEXT(a_strobe_gap, result_valid, !result_valid, "back-to-back result strobes")
	`NPS_ASSERT_NEXT(a_load_idle, start && !busy && !last_job, !busy, "run without last job")
	`NPS_ASSERT_NOW(a_tat, result_valid, turnaround_time == tat_exp, "turnaround mismatch")

endmodule

bind nonpreemptive_priority_scheduler nps_assert_checker u_nps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.last_job        (last_job),
	.result_valid    (result_valid),
	.job_arrival     (job_arrival),
	.completion_time (completion_time),
	.turnaround_time (turnaround_time),
	.last_result     (last_result)
);

// File: test/nps_checker.sv
// Scoreboard for the priority scheduler: predicts the schedule of each job set and checks results.
`timescale 1ns / 1ps

module nps_checker
	import nps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [ARR_W-1:0]  arrival_time,
	input  logic [BUR_W-1:0]  burst_time,
	input  logic [PRI_W-1:0]  priority_level,
	input  logic              last_job,
	input  logic              result_valid,
	input  logic [NUM_W-1:0]  job_number,
	input  logic [ARR_W-1:0]  job_arrival,
	input  logic [BUR_W-1:0]  job_burst,
	input  logic [TIME_W-1:0] completion_time,
	input  logic [TIME_W-1:0] turnaround_time,
	input  logic [TIME_W-1:0] waiting_time,
	input  logic [SUM_W-1:0]  total_turnaround,
	input  logic [SUM_W-1:0]  total_waiting,
	input  logic              last_result,
	output int                fail_count,
	output int                open_count
);

	localparam int          SLOTS     = MAX_JOBS_DEF;
	localparam int unsigned CLOCK_TOP = (1 << TIME_W) - 1;
	localparam int unsigned SUM_TOP   = (1 << SUM_W) - 1;

	typedef struct {
		logic [NUM_W-1:0]  num;
		logic [ARR_W-1:0]  arr;
		logic [BUR_W-1:0]  bur;
		logic [TIME_W-1:0] comp;
		logic [TIME_W-1:0] tat;
		logic [TIME_W-1:0] wt;
		logic [SUM_W-1:0]  tsum;
		logic [SUM_W-1:0]  wsum;
		logic              last;
	} sched_slot_t;

	logic [ARR_W-1:0] held_arr [SLOTS];
	logic [BUR_W-1:0] held_bur [SLOTS];
	logic [PRI_W-1:0] held_pri [SLOTS];
	int               held_cnt;
	sched_slot_t      slots_due [$];
	int               errors;

	assign fail_count = errors;
	assign open_count = slots_due.size();

	function automatic int unsigned sat_sum(input int unsigned a, b, top);
		int unsigned s;
		s = a + b;
		return (s > top) ? top : s;
	endfunction

	// Run the whole held set to completion and queue one slot per job.
	task automatic plan_schedule();
		logic [SLOTS-1:0] done;
		int unsigned      now, earliest, comp, tat, wt, tsum, wsum;
		bit               any;
		int               best;
		sched_slot_t      s;
		done = '0;
		now  = 0;
		tsum = 0;
		wsum = 0;
		for (int k = 0; k < held_cnt; k++) begin
			any      = 0;
			earliest = 32'hFFFF_FFFF;
			for (int i = 0; i < held_cnt; i++) begin
				if (!done[i]) begin
					if (held_arr[i] <= now)
						any = 1;
					if (held_arr[i] < earliest)
						earliest = held_arr[i];
				end
			end
			if (!any)
				now = earliest;
			best = -1;
			for (int i = 0; i < held_cnt; i++) begin
				if (!done[i] && held_arr[i] <= now) begin
					if (best < 0 || held_pri[i] < held_pri[best] ||
					    (held_pri[i] == held_pri[best] && held_arr[i] < held_arr[best]))
						best = i;
				end
			end
			comp = sat_sum(now, held_bur[best], CLOCK_TOP);
			tat  = comp - held_arr[best];
			wt   = (tat >= held_bur[best]) ? tat - held_bur[best] : 0;
			now  = comp;
			done[best] = 1'b1;
			tsum = sat_sum(tsum, tat, SUM_TOP);
			wsum = sat_sum(wsum, wt, SUM_TOP);
			s.num  = NUM_W'(best + 1);
			s.arr  = held_arr[best];
			s.bur  = held_bur[best];
			s.comp = TIME_W'(comp);
			s.tat  = TIME_W'(tat);
			s.wt   = TIME_W'(wt);
			s.tsum = SUM_W'(tsum);
			s.wsum = SUM_W'(wsum);
			s.last = (k + 1 == held_cnt);
			slots_due.push_back(s);
		end
		held_cnt = 0;
	endtask

	task automatic check_field(input string fname, input logic [31:0] want, got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, fname, want, got);
		end
	endtask

	always @(posedge clk) begin
		sched_slot_t s;
		if (!arst_n) begin
			held_cnt = 0;
			errors   = 0;
			slots_due.delete();
		end else begin
			if (start && !busy) begin
				if (held_cnt < SLOTS) begin
					held_arr[held_cnt] = arrival_time;
					held_bur[held_cnt] = burst_time;
					held_pri[held_cnt] = priority_level;
					held_cnt++;
				end
				if (last_job)
					plan_schedule();
			end
			if (result_valid) begin
				if (slots_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result for job %0d", $realtime, job_number);
				end else begin
					s = slots_due.pop_front();
					check_field("job_number", s.num, job_number);
					check_field("job_arrival", s.arr, job_arrival);
					check_field("job_burst", s.bur, job_burst);
					check_field("completion_time", s.comp, completion_time);
					check_field("turnaround_time", s.tat, turnaround_time);
					check_field("waiting_time", s.wt, waiting_time);
					check_field("total_turnaround", s.tsum, total_turnaround);
					check_field("total_waiting", s.wsum, total_waiting);
					check_field("last_result", s.last, last_result);
				end
			end
		end
	end

endmodule

// File: test/tb.sv
// Testbench top for the priority scheduler: clock, reset, job set stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import nps_pkg::*;

	localparam int LIMIT = 200000;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              start          = 1'b0;
	logic [ARR_W-1:0]  arrival_time   = '0;
	logic [BUR_W-1:0]  burst_time     = '0;
	logic [PRI_W-1:0]  priority_level = '0;
	logic              last_job       = 1'b0;
	logic              busy;
	logic              result_valid;
	logic [NUM_W-1:0]  job_number;
	logic [ARR_W-1:0]  job_arrival;
	logic [BUR_W-1:0]  job_burst;
	logic [TIME_W-1:0] completion_time;
	logic [TIME_W-1:0] turnaround_time;
	logic [TIME_W-1:0] waiting_time;
	logic [SUM_W-1:0]  total_turnaround;
	logic [SUM_W-1:0]  total_waiting;
	logic              last_result;
	int                fail_count;
	int                open_count;
	int                cycles = 0;
	bit                quiet  = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	nonpreemptive_priority_scheduler u_top (
		.clk, .arst_n, .start, .busy, .arrival_time, .burst_time, .priority_level,
		.last_job, .result_valid, .job_number, .job_arrival, .job_burst,
		.completion_time, .turnaround_time, .waiting_time, .total_turnaround,
		.total_waiting, .last_result
	);

	nps_checker u_chk (
		.clk, .arst_n, .start, .busy, .arrival_time, .burst_time, .priority_level,
		.last_job, .result_valid, .job_number, .job_arrival, .job_burst,
		.completion_time, .turnaround_time, .waiting_time, .total_turnaround,
		.total_waiting, .last_result, .fail_count, .open_count
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_job(input int a, b, p, input bit fin);
		if (!quiet && $urandom_range(0, 99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start          <= 1'b1;
		arrival_time   <= ARR_W'(a);
		burst_time     <= BUR_W'(b);
		priority_level <= PRI_W'(p);
		last_job       <= fin;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// One job set with random content shaped by a per-set mode.
	task automatic send_set(inout int sent, input int n);
		int base, spread, a;
		bit wide_bur, wide_pri;
		base     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 200);
		spread   = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 60);
		wide_bur = ($urandom_range(0, 4) == 0);
		wide_pri = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			a = base + $urandom_range(0, spread);
			if (a > 65535)
				a = 65535;
			send_job(a, wide_bur ? $urandom_range(0, 65535) : $urandom_range(0, 40),
			         wide_pri ? $urandom_range(0, 255) : $urandom_range(0, 3), i == n - 1);
			sent++;
		end
	endtask

	initial begin
		int sent, n;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// field extremes, then an idle gap before the next arrival
		send_job(65535, 65535, 255, 0);
		send_job(0, 0, 0, 0);
		send_job(10, 5, 255, 1);
		// single job
		send_job(100, 7, 3, 1);
		// priority ties, arrival ties, clock jump
		send_job(5, 10, 9, 0);
		send_job(2, 1, 9, 0);
		send_job(5, 3, 9, 1);
		// full store; two extra beats are dropped, the second still starts the run
		for (int i = 0; i < MAX_JOBS_DEF; i++)
			send_job($urandom_range(0, 50), $urandom_range(0, 20), $urandom_range(0, 7), 0);
		send_job(1, 1, 0, 0);
		send_job(1, 1, 0, 1);

		sent = 0;
		while (sent < 90) begin
			quiet = (sent >= 35 && sent < 65);
			case ($urandom_range(0, 7))
				0:       n = $urandom_range(MAX_JOBS_DEF + 1, MAX_JOBS_DEF + 3);
				1, 2:    n = $urandom_range(9, MAX_JOBS_DEF);
				default: n = $urandom_range(1, 8);
			endcase
			send_set(sent, n);
		end
		start <= 1'b0;

		while (open_count != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/nps_pkg.sv
rtl/core/nps_ctrl.sv
rtl/core/nps_dp.sv
rtl/core/nonpreemptive_priority_scheduler.sv
rtl/core/nps_checker.sv
test/nps_checker.sv
test/tb.sv
